// ===== rtl/seven_bit_group_unpacker_core_assert.svh =====
// Assertion macros used by the unpacker top level.
`ifndef SEVEN_BIT_GROUP_UNPACKER_CORE_ASSERT_SVH
`define SEVEN_BIT_GROUP_UNPACKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is held.
`define SBU_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("unpacker same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define SBU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("unpacker next-cycle check failed");

`else

`define SBU_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define SBU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/sbu_pkg.sv =====
// Shared types and constants of the seven-bit group unpacker.
package sbu_pkg;

    localparam int unsigned BYTE_W                = 8;
    localparam int unsigned CFG_W                 = 9;
    localparam int unsigned GROUP_SIZE            = 7;
    localparam int unsigned POS_W                 = 3;
    localparam int unsigned DEF_MAX_MESSAGE_BYTES = 256;
    localparam int unsigned DEF_QUEUE_DEPTH       = 2;

    localparam logic [CFG_W-1:0]  CFG_LEN_RESET = 9'd7;
    localparam logic [BYTE_W-1:0] START_MASK    = 8'h7F;

    // One restored group waiting to be sent out
    typedef struct packed {
        logic [GROUP_SIZE-1:0][BYTE_W-1:0] bytes;
        logic [BYTE_W-1:0]                 ovf;
        logic [POS_W-1:0]                  count;
        logic [BYTE_W-1:0]                 base_idx;
        logic                              ends_msg;
    } t_burst;

endpackage

// ===== rtl/sbu_front.sv =====
// Front end: length register, group capture and burst classification.
module sbu_front #(
    parameter int unsigned MAX_MESSAGE_BYTES = sbu_pkg::DEF_MAX_MESSAGE_BYTES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sbu_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    input  logic [sbu_pkg::BYTE_W-1:0] i_raw_byte,
    input  logic                       i_q_full,
    output logic                       o_in_stall,
    output logic                       o_push,
    output sbu_pkg::t_burst            o_push_data
);
    import sbu_pkg::*;

    localparam int unsigned LEN_W = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int unsigned CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

    logic [CFG_W-1:0]                  r_msg_len;
    logic [LEN_W-1:0]                  r_bytes_done, n_bytes_done;
    logic [POS_W-1:0]                  r_group_pos, n_group_pos;
    logic [GROUP_SIZE-1:0][BYTE_W-1:0] r_group;

    logic [CMP_W-1:0] w_len_raw;
    logic [CMP_W-1:0] w_len;
    logic [CMP_W-1:0] w_done;
    logic [CMP_W-1:0] w_left;
    logic [CMP_W-1:0] w_done_next;
    logic [POS_W-1:0] w_count;
    logic             w_accept;
    logic             w_is_data;

    // Clamp the configured length into 1 .. MAX_MESSAGE_BYTES
    always_comb begin
        w_len_raw = CMP_W'(r_msg_len);
        if (w_len_raw == '0) begin
            w_len_raw = CMP_W'(1);
        end
        w_len = (w_len_raw > CMP_W'(MAX_MESSAGE_BYTES)) ? CMP_W'(MAX_MESSAGE_BYTES) : w_len_raw;
    end

    // Restart the count when a shorter length has been written
    assign w_done  = (CMP_W'(r_bytes_done) >= w_len) ? '0 : CMP_W'(r_bytes_done);
    assign w_left  = w_len - w_done;
    assign w_count = (w_left < CMP_W'(GROUP_SIZE)) ? w_left[POS_W-1:0] : POS_W'(GROUP_SIZE);

    assign w_is_data   = (r_group_pos < w_count);
    assign o_in_stall  = i_q_full;
    assign w_accept    = i_in_valid && !i_q_full;
    assign w_done_next = w_done + CMP_W'(w_count);

    // Classify the beat: store a data byte or close the group
    always_comb begin
        n_group_pos  = r_group_pos;
        n_bytes_done = LEN_W'(w_done);
        o_push       = 1'b0;
        if (w_accept) begin
            if (w_is_data) begin
                n_group_pos = r_group_pos + POS_W'(1);
            end else begin
                o_push      = 1'b1;
                n_group_pos = '0;
                n_bytes_done = (w_done_next >= w_len) ? '0 : LEN_W'(w_done_next);
            end
        end else begin
            n_bytes_done = r_bytes_done;
        end
    end

    // Describe the finished group for the back end
    always_comb begin
        o_push_data.bytes    = r_group;
        o_push_data.ovf      = i_raw_byte;
        o_push_data.count    = w_count;
        o_push_data.base_idx = w_done[BYTE_W-1:0];
        o_push_data.ends_msg = (w_done_next == w_len);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_len    <= CFG_LEN_RESET;
            r_bytes_done <= '0;
            r_group_pos  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_msg_len <= i_cfg_data;
            end
            r_bytes_done <= n_bytes_done;
            r_group_pos  <= n_group_pos;
        end
    end

    // Hold the group's data bytes
    always_ff @(posedge i_clk) begin
        if (w_accept && w_is_data) begin
            r_group[r_group_pos] <= i_raw_byte;
        end
    end

endmodule

// ===== rtl/sbu_queue.sv =====
// Short queue of finished groups between the front and back ends.
module sbu_queue #(
    parameter int unsigned DEPTH = sbu_pkg::DEF_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sbu_pkg::t_burst i_push_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output sbu_pkg::t_burst o_pop_data
);
    import sbu_pkg::*;

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_burst           r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_full     = (r_cnt == CNT_W'(DEPTH));
    assign o_valid    = (r_cnt != '0);
    assign o_pop_data = r_mem[r_rd];
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_pop && o_valid;

    // Advance pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == IDX_W'(DEPTH - 1)) ? '0 : r_wr + IDX_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == IDX_W'(DEPTH - 1)) ? '0 : r_rd + IDX_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

// ===== rtl/sbu_back.sv =====
// Back end: sends out the bytes of one restored group per burst.
module sbu_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  sbu_pkg::t_burst            i_q_data,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [sbu_pkg::BYTE_W-1:0] o_data_byte,
    output logic [sbu_pkg::BYTE_W-1:0] o_byte_index,
    output logic                       o_burst_last,
    output logic                       o_message_end
);
    import sbu_pkg::*;

    t_burst            r_desc;
    logic              r_busy;
    logic [POS_W-1:0]  r_pos;
    logic [BYTE_W-1:0] w_byte;
    logic              w_first;
    logic              w_accept;

    assign o_out_valid = r_busy;
    assign w_accept    = r_busy && !i_out_stall;
    assign w_byte      = r_desc.bytes[r_pos];
    assign w_first     = (r_pos == '0);

    // Restore the byte: drop the start marker on the first, merge the top bit
    always_comb begin
        o_data_byte = w_first ? (w_byte & START_MASK) : w_byte;
        o_data_byte[BYTE_W-1] = o_data_byte[BYTE_W-1] | r_desc.ovf[r_pos];
    end

    assign o_byte_index  = r_desc.base_idx + BYTE_W'(r_pos);
    assign o_burst_last  = (r_pos == r_desc.count - POS_W'(1));
    assign o_message_end = o_burst_last && r_desc.ends_msg;

    // Take the next group when idle or when the last beat leaves
    assign o_pop = i_q_valid && (!r_busy || (w_accept && o_burst_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_pos  <= '0;
            end else if (w_accept) begin
                if (o_burst_last) begin
                    r_busy <= 1'b0;
                    r_pos  <= '0;
                end else begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
        end
    end

    // Load the group descriptor
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_q_data;
        end
    end

endmodule

// ===== rtl/seven_bit_group_unpacker_core.sv =====
// Top level of the seven-bit group unpacker.
//
// Input channel (i_in_valid / o_in_stall / i_raw_byte): raw serial bytes of a
// message, groups of up to seven data bytes each followed by an overflow byte.
// Output channel (o_out_valid / i_out_stall / o_data_byte, o_byte_index,
// o_burst_last, o_message_end): one restored data byte per beat.
// i_cfg_we / i_cfg_data write the message length (data bytes per message).
// Input beats are taken one per cycle unless the queue is full. A data byte produces nothing; the
// overflow byte closes the group, which goes into a two-entry burst queue.
// The first restored byte is offered once the group has passed the queue
// entry and the back end's descriptor register; a group of n bytes then
// leaves at one beat per cycle while i_out_stall is low, with the next
// queued group following without a gap.
// The input side stalls only while the burst queue is full, which happens when
// the receiver stalls long enough for two closed groups to pile up.
// While i_out_stall is high the output beat is held unchanged.
// Synchronous reset clears the group position, the message byte count and the
// queue, and sets the message length to seven.
`include "seven_bit_group_unpacker_core_assert.svh"

module seven_bit_group_unpacker_core #(
    parameter int unsigned MAX_MESSAGE_BYTES = sbu_pkg::DEF_MAX_MESSAGE_BYTES,
    parameter int unsigned QUEUE_DEPTH       = sbu_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sbu_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [sbu_pkg::BYTE_W-1:0] i_raw_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [sbu_pkg::BYTE_W-1:0] o_data_byte,
    output logic [sbu_pkg::BYTE_W-1:0] o_byte_index,
    output logic                       o_burst_last,
    output logic                       o_message_end
);
    import sbu_pkg::*;

    logic   w_push;
    t_burst w_push_data;
    logic   w_q_full;
    logic   w_q_valid;
    logic   w_pop;
    t_burst w_pop_data;

    // Capture groups and classify beats
    sbu_front #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_raw_byte  (i_raw_byte),
        .i_q_full    (w_q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // Decouple the two sides
    sbu_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_full      (w_q_full),
        .o_valid     (w_q_valid),
        .o_pop_data  (w_pop_data)
    );

    // Send out restored bytes
    sbu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_data      (w_pop_data),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_data_byte   (o_data_byte),
        .o_byte_index  (o_byte_index),
        .o_burst_last  (o_burst_last),
        .o_message_end (o_message_end)
    );

    // The end of a message always closes a burst
    `SBU_ASSERT_IMPLIES(a_end_is_last, i_clk, i_rst_n, o_out_valid && o_message_end, o_burst_last)

    // Within a burst the next byte follows at once with the next index
    `SBU_ASSERT_NEXT(a_burst_runs_on, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_burst_last, o_out_valid && (o_byte_index == 8'($past(o_byte_index) + 8'd1)))

    // An idle back end picks up a waiting group in the next cycle
    `SBU_ASSERT_NEXT(a_queue_drains, i_clk, i_rst_n, w_q_valid && !o_out_valid, o_out_valid)

endmodule

// ===== sim/tb_seven_bit_group_unpacker_core.sv =====
// Testbench for the seven-bit group unpacker: directed and random byte streams with a predictor.
`timescale 1ns / 100ps

module tb_seven_bit_group_unpacker_core;
    import sbu_pkg::*;

    localparam int unsigned MAX_MSG     = DEF_MAX_MESSAGE_BYTES;
    localparam int unsigned SETTLE_CYC  = 8;
    localparam int unsigned HOLD_CYC    = 300;
    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned MAX_REPORTS = 10;

    // One restored data byte as seen on the output channel
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] idx;
        logic              last;
        logic              mend;
    } t_restored;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [CFG_W-1:0]   i_cfg_data  = '0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    logic [BYTE_W-1:0]  i_raw_byte  = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [BYTE_W-1:0]  o_data_byte;
    logic [BYTE_W-1:0]  o_byte_index;
    logic               o_burst_last;
    logic               o_message_end;

    // Predictor state
    logic [CFG_W-1:0]   model_len   = CFG_LEN_RESET;
    logic [BYTE_W-1:0]  held_bytes [GROUP_SIZE];
    int unsigned        held_count  = 0;
    int unsigned        msg_emitted = 0;
    t_restored          restored_q [$];

    int unsigned        bad_beats      = 0;
    int unsigned        raw_sent       = 0;
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    bit                 hold_off_req   = 1'b0;
    int unsigned        hold_left      = 0;

    seven_bit_group_unpacker_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_raw_byte    (i_raw_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_data_byte   (o_data_byte),
        .o_byte_index  (o_byte_index),
        .o_burst_last  (o_burst_last),
        .o_message_end (o_message_end)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Store a data byte, or restore the held group when the overflow byte arrives
    task automatic unpack_raw(input logic [BYTE_W-1:0] raw);
        int unsigned eff, left, n, k;
        t_restored   r;
        eff = (model_len == 0) ? 1 : ((model_len > MAX_MSG) ? MAX_MSG : model_len);
        if (msg_emitted >= eff)
            msg_emitted = 0;
        left = eff - msg_emitted;
        n = (left < GROUP_SIZE) ? left : GROUP_SIZE;
        if (held_count < n) begin
            held_bytes[held_count] = raw;
            held_count++;
        end else begin
            for (k = 0; k < n; k++) begin
                r.data = held_bytes[k];
                if (k == 0)
                    r.data = r.data & START_MASK;
                r.data[BYTE_W-1] = r.data[BYTE_W-1] | raw[k];
                r.idx  = BYTE_W'(msg_emitted + k);
                r.last = (k + 1 == n);
                r.mend = (msg_emitted + k + 1 == eff);
                restored_q = {restored_q, r};
            end
            msg_emitted += n;
            if (msg_emitted >= eff)
                msg_emitted = 0;
            held_count = 0;
        end
    endtask

    // Compare one output beat with the oldest predicted byte
    task automatic check_beat(input t_restored got);
        t_restored want;
        if (restored_q.size() == 0) begin
            bad_beats++;
            if (bad_beats <= MAX_REPORTS)
                $display("unexpected beat: data %h idx %0d last %b end %b",
                         got.data, got.idx, got.last, got.mend);
        end else begin
            want = restored_q.pop_front();
            if (got.data !== want.data || got.idx !== want.idx ||
                got.last !== want.last || got.mend !== want.mend) begin
                bad_beats++;
                if (bad_beats <= MAX_REPORTS)
                    $display("mismatch: expected data %h idx %0d last %b end %b, got data %h idx %0d last %b end %b",
                             want.data, want.idx, want.last, want.mend,
                             got.data, got.idx, got.last, got.mend);
            end
        end
    endtask

    // Watch both channels and the register port at each rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                check_beat('{o_data_byte, o_byte_index, o_burst_last, o_message_end});
            if (i_in_valid && !o_in_stall)
                unpack_raw(i_raw_byte);
            if (i_cfg_we)
                model_len = i_cfg_data;
        end
    end

    // Drive the receiver stall, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off_req) begin
            hold_left = HOLD_CYC;
            hold_off_req = 1'b0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // End the run when no beat moves for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Offer one raw byte and hold it until the block takes it
    task automatic send_raw(input logic [BYTE_W-1:0] b);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_raw_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        raw_sent++;
    endtask

    // Drop valid, wait for every predicted byte, then let the pipeline settle
    task automatic settle_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (restored_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_msg_len(input logic [CFG_W-1:0] len);
        settle_idle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= len;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // One well-formed message with random content
    task automatic send_message(input int unsigned len_eff);
        int unsigned left, n, k;
        left = len_eff;
        while (left > 0) begin
            n = (left < GROUP_SIZE) ? left : GROUP_SIZE;
            for (k = 0; k < n; k++)
                send_raw(BYTE_W'($urandom));
            send_raw(BYTE_W'($urandom));
            left -= n;
        end
    endtask

    // Reset length: first byte loses its marker, overflow bits merge in
    task automatic test_default_length();
        send_raw(8'hFF);
        send_raw(8'h80);
        send_raw(8'h7F);
        send_raw(8'h00);
        send_raw(8'hAA);
        send_raw(8'h55);
        send_raw(8'h01);
        send_raw(8'hB5);
    endtask

    // Length zero acts as one data byte per message
    task automatic test_zero_length();
        set_msg_len(9'd0);
        send_raw(8'hFF);
        send_raw(8'h01);
        send_raw(8'hFF);
        send_raw(8'hFE);
    endtask

    // Shrink the length after the first group so the next group starts a new message
    task automatic test_length_change();
        set_msg_len(9'd9);
        send_raw(8'h81);
        send_raw(8'hC2);
        send_raw(8'hFF);
        send_raw(8'h80);
        send_raw(8'h3C);
        send_raw(8'h91);
        send_raw(8'hE7);
        send_raw(8'h00);
        set_msg_len(9'd3);
        send_raw(8'h12);
        send_raw(8'h34);
        send_raw(8'h56);
        send_raw(8'hFF);
    endtask

    // Shrink the group below the bytes already held: next byte closes the group
    task automatic test_full_group();
        set_msg_len(9'd7);
        send_raw(8'h11);
        send_raw(8'h22);
        send_raw(8'h33);
        send_raw(8'h44);
        send_raw(8'h55);
        set_msg_len(9'd2);
        send_raw(8'h02);
    endtask

    // Hold the receiver off so the burst queue fills and the input stalls
    task automatic test_backpressure();
        int unsigned k;
        set_msg_len(9'd7);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 1'b1;
        for (k = 0; k < 4; k++)
            send_message(7);
    endtask

    // Random lengths and messages, with trailing partial groups as noise
    task automatic test_random_mix(input int s_pct, input int r_pct,
                                   input int unsigned budget);
        int unsigned start, len_cfg, msgs, extra, k;
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        start = raw_sent;
        while (raw_sent - start < budget) begin
            len_cfg = $urandom_range(0, 12);
            set_msg_len(CFG_W'(len_cfg));
            msgs = $urandom_range(1, 2);
            for (k = 0; k < msgs; k++)
                send_message((len_cfg == 0) ? 1 : len_cfg);
            if ($urandom_range(0, 1)) begin
                extra = $urandom_range(1, 6);
                for (k = 0; k < extra; k++)
                    send_raw(BYTE_W'($urandom));
            end
        end
    endtask

    // Length above the maximum is clamped: one full maximal message
    task automatic test_oversize_length();
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        set_msg_len(9'h1FF);
        send_message(MAX_MSG);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_default_length();
        test_zero_length();
        test_length_change();
        test_full_group();
        test_backpressure();
        test_random_mix(0, 0, 6);
        test_random_mix(77, 0, 6);
        test_random_mix(0, 77, 6);
        test_random_mix(12, 12, 6);
        test_oversize_length();
        settle_idle();
        if (bad_beats == 0 && restored_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== seven_bit_group_unpacker_core.f =====
+incdir+rtl
rtl/sbu_pkg.sv
rtl/sbu_front.sv
rtl/sbu_queue.sv
rtl/sbu_back.sv
rtl/seven_bit_group_unpacker_core.sv
sim/tb_seven_bit_group_unpacker_core.sv
